### hw/rtl/tmma_pkg.sv
// tmma_pkg: shared types and constants for the tile multiply-accumulate block
// no dependencies

package tmma_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned SIZE_W = 5;

	typedef enum logic [1:0] {
		OP_LOAD_AB = 2'd0,
		OP_LOAD_C = 2'd1,
		OP_MAC = 2'd2,
		OP_READ_C = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] column;
		logic signed [WORD_W-1:0] a_value;
		logic signed [WORD_W-1:0] b_value;
		logic signed [WORD_W-1:0] c_value;
	} in_beat_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		logic out_of_range;
	} out_beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_MAC,
		ST_DRAIN
	} state_t;

endpackage

### hw/rtl/tile_matrix_multiply_accumulate.sv
// tile_matrix_multiply_accumulate: top level, sequencer, C tile memory and cell chain
// depends on tmma_pkg and tmma_cell
//
// channel | signals                       | meaning
// cmd     | start, busy, cmd              | one operation beat, taken when start and !busy
// rsp     | done, rsp                     | one result beat, valid for one cycle, no stall
// cfg     | tile_size_we, tile_size_wdata | tile size register
//
// load and read: the accepting edge sets pend_q, which then sets done; busy stays high until done rises
// multiply: the n*n C elements are issued one per cycle, each passing the issue stage and
//   the cell chain before its write-back; done rises once the drain state has ended
// after reset a clearing pass zeroes every C entry with busy high
// done cannot be stalled

module tile_matrix_multiply_accumulate
	import tmma_pkg::*;
#(
	parameter int unsigned MAX_TILE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_beat_t cmd,
	output logic done,
	output out_beat_t rsp,
	input  logic tile_size_we,
	input  logic [SIZE_W-1:0] tile_size_wdata
);

	localparam int unsigned DEPTH = MAX_TILE * MAX_TILE;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned TW = $clog2(MAX_TILE + 1);
	localparam int unsigned KW = $clog2(MAX_TILE);

	logic [SIZE_W-1:0] size_q;
	logic [TW-1:0] n_eff;
	state_t state_q, state_d;

	logic [WORD_W-1:0] cmem [DEPTH];

	logic accept;
	logic mac_go;
	logic load_ab;
	logic load_c;
	logic outside;
	logic [AW-1:0] cell_addr;
	logic [AW-1:0] issue_addr;
	logic [AW-1:0] wb_addr;
	logic [AW-1:0] clr_q;
	logic pend_q;
	op_t op_q;
	logic oor_q;
	logic [WORD_W-1:0] cread_q;

	// element counter (i, j) for the multiply
	logic [TW-1:0] i_q, j_q;
	logic [TW-1:0] n_q;
	logic [TW-1:0] drain_q;
	logic issue;
	logic iss_v_s1;
	logic [KW-1:0] iss_i_s1, iss_j_s1;
	logic [WORD_W-1:0] c_s1;

	// chain links: element valid, indexes and running sum
	logic ch_v [MAX_TILE+1];
	logic [KW-1:0] ch_i [MAX_TILE+1];
	logic [KW-1:0] ch_j [MAX_TILE+1];
	logic [WORD_W-1:0] ch_acc [MAX_TILE+1];

	// effective tile size saturates at MAX_TILE
	always_comb begin
		if (32'(size_q) > 32'(MAX_TILE))
			n_eff = TW'(MAX_TILE);
		else
			n_eff = TW'(size_q);
	end

	// tile size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(16);
		end else if (tile_size_wdata != tile_size_wdata || tile_size_we) begin
			size_q <= tile_size_wdata;
		end
	end

	// decode of the command beat
	assign outside = (32'(cmd.row) >= 32'(n_eff)) || (32'(cmd.column) >= 32'(n_eff));
	assign cell_addr = AW'(cmd.row * MAX_TILE + cmd.column);
	assign accept = start && !busy;
	assign mac_go = accept && (cmd.operation == OP_MAC) && (n_eff != '0);
	assign load_ab = accept && !outside && (cmd.operation == OP_LOAD_AB);
	assign load_c = accept && !outside && (cmd.operation == OP_LOAD_C);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: if (mac_go) state_d = ST_MAC;
			ST_MAC: if (i_q == n_q - 1'b1 && j_q == n_q - 1'b1) state_d = ST_DRAIN;
			ST_DRAIN: if (drain_q == '0) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy = 1'b1;
		issue = 1'b0;
		case (state_q)
			ST_IDLE: busy = pend_q;
			ST_MAC: issue = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			pend_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			n_q <= '0;
			drain_q <= '0;
			iss_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			pend_q <= (accept && !mac_go) || (state_q == ST_DRAIN && drain_q == '0);
			if (mac_go) begin
				i_q <= '0;
				j_q <= '0;
				n_q <= n_eff;
			end else if (issue) begin
				if (j_q == n_q - 1'b1) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			// the drain counter waits for the last issued element to leave the chain
			if (state_q == ST_MAC && state_d == ST_DRAIN) drain_q <= TW'(MAX_TILE);
			else if (drain_q != '0) drain_q <= drain_q - 1'b1;
			iss_v_s1 <= issue;
		end
	end

	assign issue_addr = AW'(i_q * MAX_TILE + j_q);

	// issue stage and the fields kept for the result beat
	always_ff @(posedge clk) begin
		iss_i_s1 <= i_q[KW-1:0];
		iss_j_s1 <= j_q[KW-1:0];
		if (accept) begin
			op_q <= op_t'(cmd.operation);
			oor_q <= outside;
		end
	end

	assign ch_v[0] = iss_v_s1;
	assign ch_i[0] = iss_i_s1;
	assign ch_j[0] = iss_j_s1;
	assign ch_acc[0] = c_s1;

	// cell k holds column k of A and row k of B
	genvar k;
	generate
		for (k = 0; k < MAX_TILE; k++) begin : g_chain
			logic a_we, b_we, en;
			assign a_we = load_ab && (KW'(cmd.column) == KW'(k));
			assign b_we = load_ab && (KW'(cmd.row) == KW'(k));
			assign en = TW'(k) < n_q;
			tmma_cell #(.DEPTH(MAX_TILE), .IW(KW)) u_cell (
				.clk(clk), .arst_n(arst_n), .mac_en(en),
				.a_we(a_we), .a_waddr(KW'(cmd.row)), .a_wdata(cmd.a_value),
				.b_we(b_we), .b_waddr(KW'(cmd.column)), .b_wdata(cmd.b_value),
				.v_in(ch_v[k]), .i_in(ch_i[k]), .j_in(ch_j[k]), .acc_in(ch_acc[k]),
				.v_out(ch_v[k+1]), .i_out(ch_i[k+1]), .j_out(ch_j[k+1]),
				.acc_out(ch_acc[k+1])
			);
		end
	endgenerate

	assign wb_addr = AW'(ch_i[MAX_TILE] * MAX_TILE + ch_j[MAX_TILE]);

	// C tile: clear pass, multiply write-back, load, and the two reads
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) cmem[clr_q] <= '0;
		else if (ch_v[MAX_TILE]) cmem[wb_addr] <= ch_acc[MAX_TILE];
		else if (load_c) cmem[cell_addr] <= cmd.c_value;
		c_s1 <= cmem[issue_addr];
		if (accept) cread_q <= cmem[cell_addr];
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= pend_q;
		end
	end

	always_ff @(posedge clk) begin
		rsp.out_of_range <= (op_q != OP_MAC) && oor_q;
		rsp.result_value <= (op_q == OP_READ_C && !oor_q) ? cread_q : '0;
	end

endmodule

### hw/rtl/tmma_cell.sv
// tmma_cell: one multiply-accumulate cell of the chain, holding one A column and one B row
// depends on tmma_pkg

module tmma_cell
	import tmma_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IW = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic mac_en,
	input  logic a_we,
	input  logic [IW-1:0] a_waddr,
	input  logic [WORD_W-1:0] a_wdata,
	input  logic b_we,
	input  logic [IW-1:0] b_waddr,
	input  logic [WORD_W-1:0] b_wdata,
	input  logic v_in,
	input  logic [IW-1:0] i_in,
	input  logic [IW-1:0] j_in,
	input  logic [WORD_W-1:0] acc_in,
	output logic v_out,
	output logic [IW-1:0] i_out,
	output logic [IW-1:0] j_out,
	output logic [WORD_W-1:0] acc_out
);

	// a_col[i] is A[i][k], b_row[j] is B[k][j] for this cell's k
	logic [WORD_W-1:0] a_col [DEPTH];
	logic [WORD_W-1:0] b_row [DEPTH];

	logic [WORD_W-1:0] a_s1;
	logic [WORD_W-1:0] b_s1;
	logic [WORD_W-1:0] acc_s1;
	logic [WORD_W-1:0] prod;
	logic [IW-1:0] i_s1;
	logic [IW-1:0] j_s1;
	logic v_s1;
	logic mac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			mac_s1 <= 1'b0;
		end else begin
			v_s1 <= v_in;
			mac_s1 <= v_in && mac_en;
		end
	end

	// operand stores and the registered read for the passing element
	always_ff @(posedge clk) begin
		if (a_we) a_col[a_waddr] <= a_wdata;
		if (b_we) b_row[b_waddr] <= b_wdata;
		a_s1 <= a_col[i_in];
		b_s1 <= b_row[j_in];
		acc_s1 <= acc_in;
		i_s1 <= i_in;
		j_s1 <= j_in;
	end

	// add own product (low word) for a valid element in an enabled cell, and hand the sum on
	assign prod = a_s1 * b_s1;
	assign acc_out = mac_s1 ? acc_s1 + prod : acc_s1;
	assign v_out = v_s1;
	assign i_out = i_s1;
	assign j_out = j_s1;

endmodule

### tb/tmma_checker.sv
// tmma_checker: predicts and checks result beats of the tile multiply-accumulate block
// depends on tmma_pkg

module tmma_checker
	import tmma_pkg::*;
#(
	parameter int unsigned MAX_TILE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  in_beat_t cmd,
	input  logic done,
	input  out_beat_t rsp,
	input  logic tile_size_we,
	input  logic [SIZE_W-1:0] tile_size_wdata,
	output int errors,
	output int pending
);

	logic [31:0] a_mem [MAX_TILE*MAX_TILE];
	logic [31:0] b_mem [MAX_TILE*MAX_TILE];
	logic [31:0] c_mem [MAX_TILE*MAX_TILE];
	logic [SIZE_W-1:0] size_reg;
	out_beat_t rsp_q [$];

	assign pending = rsp_q.size();

	// apply one command beat to the tile copies and queue its result
	task automatic apply_beat(input in_beat_t b);
		int n;
		int idx;
		logic [31:0] acc;
		out_beat_t r;
		begin
			n = (size_reg > MAX_TILE) ? MAX_TILE : size_reg;
			idx = b.row * MAX_TILE + b.column;
			r = '0;
			if (op_t'(b.operation) == OP_MAC) begin
				for (int i = 0; i < n; i++)
					for (int j = 0; j < n; j++) begin
						acc = c_mem[i*MAX_TILE+j];
						for (int k = 0; k < n; k++)
							acc = acc + a_mem[i*MAX_TILE+k] * b_mem[k*MAX_TILE+j];
						c_mem[i*MAX_TILE+j] = acc;
					end
			end else if (b.row >= n || b.column >= n) begin
				r.out_of_range = 1'b1;
			end else if (op_t'(b.operation) == OP_LOAD_AB) begin
				a_mem[idx] = b.a_value;
				b_mem[idx] = b.b_value;
			end else if (op_t'(b.operation) == OP_LOAD_C) begin
				c_mem[idx] = b.c_value;
			end else begin
				r.result_value = c_mem[idx];
			end
			rsp_q.push_back(r);
		end
	endtask

	// watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		out_beat_t e;
		if (!arst_n) begin
			errors <= 0;
			size_reg = 16;
			rsp_q.delete();
			for (int i = 0; i < MAX_TILE*MAX_TILE; i++) begin
				a_mem[i] = '0;
				b_mem[i] = '0;
				c_mem[i] = '0;
			end
		end else begin
			if (done) begin
				if (rsp_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result beat %h", rsp);
					errors <= errors + 1;
				end else begin
					e = rsp_q.pop_front();
					if (rsp.result_value !== e.result_value ||
						rsp.out_of_range !== e.out_of_range) begin
						if (errors < 10)
							$display("mismatch: expected value %h flag %b, got value %h flag %b",
								e.result_value, e.out_of_range,
								rsp.result_value, rsp.out_of_range);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				apply_beat(cmd);
			if (tile_size_we)
				size_reg = tile_size_wdata;
		end
	end

endmodule

### tb/tile_matrix_multiply_accumulate_tb.sv
// tile_matrix_multiply_accumulate_tb: stimulus and verdict for the tile block
// depends on tmma_pkg, tmma_checker and the block itself

module tile_matrix_multiply_accumulate_tb;
	import tmma_pkg::*;

	localparam int unsigned MAX_TILE = 16;
	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_beat_t cmd;
	logic done;
	out_beat_t rsp;
	logic tile_size_we;
	logic [SIZE_W-1:0] tile_size_wdata;
	int errors;
	int pending;
	int quiet;
	int cur_size;
	bit written [MAX_TILE*MAX_TILE];

	tile_matrix_multiply_accumulate #(.MAX_TILE(MAX_TILE)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .tile_size_we(tile_size_we),
		.tile_size_wdata(tile_size_wdata)
	);

	tmma_checker #(.MAX_TILE(MAX_TILE)) chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .tile_size_we(tile_size_we),
		.tile_size_wdata(tile_size_wdata), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog on cycles without any accepted beat or result beat
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			quiet <= 0;
		else begin
			quiet <= quiet + 1;
			if (quiet >= WATCHDOG) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// send one command beat, held until accepted
	task automatic send_beat(input op_t op, input int r, input int c,
		input logic [31:0] av, input logic [31:0] bv, input logic [31:0] cv);
		int gap;
		begin
			gap = $urandom_range(0, 4);
			repeat (gap) @(negedge clk);
			cmd.operation <= op;
			cmd.row <= IDX_W'(r);
			cmd.column <= IDX_W'(c);
			cmd.a_value <= av;
			cmd.b_value <= bv;
			cmd.c_value <= cv;
			start <= 1'b1;
			@(posedge clk);
			while (busy) @(posedge clk);
			@(negedge clk);
			start <= 1'b0;
			if (op == OP_LOAD_AB && r < cur_size && c < cur_size)
				written[r*MAX_TILE+c] = 1'b1;
		end
	endtask

	// wait until all results are back and the block has settled
	task automatic drain;
		begin
			while (pending != 0) @(negedge clk);
			repeat (8) @(negedge clk);
			while (busy) @(negedge clk);
		end
	endtask

	task automatic set_size(input int s);
		begin
			drain();
			tile_size_we <= 1'b1;
			tile_size_wdata <= SIZE_W'(s);
			@(negedge clk);
			tile_size_we <= 1'b0;
			cur_size = (s > MAX_TILE) ? MAX_TILE : s;
		end
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	// a multiply is only legal once every in-use A and B entry is written
	function automatic bit mac_ok();
		for (int i = 0; i < cur_size; i++)
			for (int j = 0; j < cur_size; j++)
				if (!written[i*MAX_TILE+j])
					return 1'b0;
		return 1'b1;
	endfunction

	task automatic fill_ab;
		begin
			for (int i = 0; i < cur_size; i++)
				for (int j = 0; j < cur_size; j++)
					send_beat(OP_LOAD_AB, i, j, rnd_word(), rnd_word(), 0);
		end
	endtask

	initial begin
		int sizes [6];
		int op;
		sizes = '{1, 2, 3, 4, 0, 31};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		tile_size_we = 1'b0;
		tile_size_wdata = '0;
		cur_size = 16;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		while (busy) @(negedge clk);

		// directed: reset contents, extremes, out of range
		send_beat(OP_READ_C, 0, 0, 0, 0, 0);
		send_beat(OP_READ_C, 15, 15, 0, 0, 0);
		send_beat(OP_LOAD_C, 15, 15, 0, 0, 32'h8000_0000);
		send_beat(OP_READ_C, 15, 15, 0, 0, 0);
		set_size(2);
		send_beat(OP_LOAD_AB, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
		send_beat(OP_LOAD_AB, 0, 1, 32'hffff_ffff, 32'hffff_ffff, 0);
		send_beat(OP_LOAD_AB, 1, 0, 32'h8000_0000, 32'h7fff_ffff, 0);
		send_beat(OP_LOAD_AB, 1, 1, 32'h0000_0003, 32'hffff_fffe, 0);
		send_beat(OP_LOAD_AB, 2, 1, 5, 5, 32'hffff_ffff);
		send_beat(OP_LOAD_C, 1, 1, 0, 0, 32'h7fff_ffff);
		send_beat(OP_MAC, 15, 15, 0, 0, 0);
		send_beat(OP_MAC, 0, 0, 0, 0, 0);
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++)
				send_beat(OP_READ_C, i, j, 0, 0, 0);
		send_beat(OP_READ_C, 15, 15, 0, 0, 0);
		set_size(0);
		send_beat(OP_MAC, 0, 0, 0, 0, 0);
		send_beat(OP_READ_C, 0, 0, 0, 0, 0);
		set_size(31);
		send_beat(OP_READ_C, 15, 15, 0, 0, 0);
		send_beat(OP_READ_C, 1, 1, 0, 0, 0);

		// random phases over several sizes, mostly small tiles
		for (int ph = 0; ph < 12; ph++) begin
			set_size(ph < 6 ? sizes[ph] : $urandom_range(1, 5));
			if (ph == 11) set_size(16);
			fill_ab();
			for (int it = 0; it < 60; it++) begin
				op = $urandom_range(0, 9);
				if (op < 3)
					send_beat(OP_LOAD_AB, $urandom_range(0, 15) % (cur_size + 1 + ph),
						$urandom_range(0, 15) % (cur_size + 1 + ph), rnd_word(), rnd_word(),
						$urandom);
				else if (op < 5)
					send_beat(OP_LOAD_C, $urandom_range(0, 15) % (cur_size + 1 + ph),
						$urandom_range(0, 15) % (cur_size + 1 + ph), $urandom, $urandom,
						rnd_word());
				else if (op == 5 && mac_ok() && (cur_size < 8 || it % 25 == 0))
					send_beat(OP_MAC, $urandom_range(0, 15), $urandom_range(0, 15),
						$urandom, $urandom, $urandom);
				else
					send_beat(OP_READ_C, $urandom_range(0, 15) % (cur_size + 1 + ph),
						$urandom_range(0, 15) % (cur_size + 1 + ph), $urandom, $urandom,
						$urandom);
				if (it == 50)
					while (pending != 0) @(negedge clk);
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
